@@ rtl/ric_pkg.sv @@
// Shared constants, codes and controller/datapath command types for the
// reprojection inlier check. No dependencies.
`default_nettype none
package ric_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TOTAL_W    = 16;
  localparam int DIV_STEPS  = 40;
  localparam int DIV_CNT_W  = 6;
  localparam int MAC_STEPS  = 3;
  localparam int ACC_W      = 50;
  localparam int MAG_W      = 49;
  localparam int PROD_W     = 81;
  localparam int DEN_W      = 61;
  localparam int DIFF_W     = 18;
  localparam logic signed [DIFF_W-1:0] DIFF_LIMIT = 18'sd65520;

  // verdict codes
  localparam logic [1:0] VERDICT_INLIER  = 2'd0;
  localparam logic [1:0] VERDICT_INVALID = 2'd1;
  localparam logic [1:0] VERDICT_DEPTH   = 2'd2;
  localparam logic [1:0] VERDICT_ERROR   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [2:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [2:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [2:0] REG_TRANSLATION = 3'd3;
  localparam logic [2:0] REG_FOCAL       = 3'd4;
  localparam logic [2:0] REG_CENTER      = 3'd5;
  localparam logic [2:0] REG_ERROR_LIMIT = 3'd6;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic mac;
    logic check;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic diff;
    logic sqr;
    logic cmp;
    logic emit;
  } ric_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic point_ok;
    logic out_busy;
  } ric_sts_t;

endpackage
`default_nettype wire

@@ rtl/ric_in_if.sv @@
// Input channel interface: one map point with its keypoint per word.
// Depends on nothing.
`default_nettype none
interface ric_in_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [15:0]        key_u;
  logic [15:0]        key_v;
  logic               last_point;

  modport source (output valid, point_valid, point_x, point_y, point_z, key_u, key_v,
                  last_point, input ready);
  modport sink (input valid, point_valid, point_x, point_y, point_z, key_u, key_v,
                last_point, output ready);
endinterface
`default_nettype wire

@@ rtl/ric_out_if.sv @@
// Result channel interface: verdict and running inlier count per word.
// Depends on nothing.
`default_nettype none
interface ric_out_if;
  logic        valid;
  logic        ready;
  logic        is_inlier;
  logic [1:0]  verdict;
  logic [15:0] inlier_total;
  logic        last_result;

  modport source (output valid, is_inlier, verdict, inlier_total, last_result,
                  input ready);
  modport sink (input valid, is_inlier, verdict, inlier_total, last_result,
                output ready);
endinterface
`default_nettype wire

@@ rtl/ric_datapath.sv @@
// Datapath: pose registers, camera transform MACs, projection multiply,
// shared-divisor restoring dividers, error compare, counter, output register. Uses ric_pkg.
`default_nettype none
module ric_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic              in_point_valid,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic [15:0]       in_key_u,
  input  wire logic [15:0]       in_key_v,
  input  wire logic              in_last_point,
  input  wire logic [1:0]        mac_sel,
  input  wire ric_pkg::ric_cmd_t cmd,
  output ric_pkg::ric_sts_t      sts,
  ric_out_if.source              out_ch
);

  // configuration registers
  logic [47:0] rot_r [3];
  logic [62:0] trans_r;
  logic [63:0] focal_r;
  logic [31:0] center_r;
  logic [15:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'd16384;
      rot_r[1] <= 48'd16384 << 16;
      rot_r[2] <= 48'd16384 << 32;
      trans_r  <= '0;
      focal_r  <= '0;
      center_r <= '0;
      limit_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ric_pkg::REG_ROT_ROW0:    rot_r[0] <= cfg_data[47:0];
        ric_pkg::REG_ROT_ROW1:    rot_r[1] <= cfg_data[47:0];
        ric_pkg::REG_ROT_ROW2:    rot_r[2] <= cfg_data[47:0];
        ric_pkg::REG_TRANSLATION: trans_r  <= cfg_data[62:0];
        ric_pkg::REG_FOCAL:       focal_r  <= cfg_data;
        ric_pkg::REG_CENTER:      center_r <= cfg_data[31:0];
        ric_pkg::REG_ERROR_LIMIT: limit_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured input word
  logic               pv_r, last_r;
  logic signed [31:0] pt_r [3];
  logic [15:0]        key_r [2];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pv_r     <= in_point_valid;
      last_r   <= in_last_point;
      pt_r[0]  <= in_point_x;
      pt_r[1]  <= in_point_y;
      pt_r[2]  <= in_point_z;
      key_r[0] <= in_key_u;
      key_r[1] <= in_key_v;
    end
  end

  // camera transform: one row coefficient times one point coordinate per lane per cycle
  logic signed [ric_pkg::ACC_W-1:0] acc_r [3];
  logic signed [31:0]               pt_sel;
  logic signed [47:0]               mac_prod [3];

  always_comb begin
    pt_sel = pt_r[mac_sel];
    for (int k = 0; k < 3; k++) begin
      mac_prod[k] = $signed(rot_r[k][16*mac_sel +: 16]) * pt_sel;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.load) begin
        acc_r[k] <= {{9{trans_r[21*k+20]}}, trans_r[21*k +: 21], 20'b0};
      end else if (cmd.mac) begin
        acc_r[k] <= acc_r[k] + ric_pkg::ACC_W'(mac_prod[k]);
      end
    end
  end

  logic zc_pos;
  assign zc_pos = !acc_r[2][ric_pkg::ACC_W-1] && (|acc_r[2]);

  // projection multiply fx*|Xc| and fy*|Yc|, split in two partial products
  logic [ric_pkg::MAG_W-1:0]  mag [2];
  logic                       neg [2];
  logic [63:0]                pp_lo [2];
  logic [48:0]                pp_hi [2];
  logic [ric_pkg::PROD_W-1:0] prod_r [2];
  logic [ric_pkg::DEN_W-1:0]  den;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      neg[k]   = acc_r[k][ric_pkg::ACC_W-1];
      mag[k]   = neg[k] ? ric_pkg::MAG_W'(-acc_r[k]) : ric_pkg::MAG_W'(acc_r[k]);
      pp_lo[k] = mag[k][31:0] * focal_r[32*k +: 32];
      pp_hi[k] = mag[k][48:32] * focal_r[32*k +: 32];
    end
    den = {acc_r[2][48:0], 12'b0};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (cmd.mul_lo) begin
        prod_r[k] <= ric_pkg::PROD_W'(pp_lo[k]);
      end else if (cmd.mul_hi) begin
        prod_r[k] <= prod_r[k] + {pp_hi[k], 32'b0};
      end
    end
  end

  // restoring division, one quotient bit per cycle, both lanes share the divisor
  logic [ric_pkg::DEN_W-1:0] rem_r [2];
  logic [39:0]               low_r [2];
  logic [39:0]               quo_r [2];
  logic                      sat_r [2];
  logic [ric_pkg::DEN_W:0]   trial [2];
  logic                      take [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      trial[k] = {rem_r[k], low_r[k][39]};
      take[k]  = trial[k] >= {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (cmd.div_init) begin
        sat_r[k] <= ric_pkg::DEN_W'(prod_r[k][80:40]) >= den;
        rem_r[k] <= ric_pkg::DEN_W'(prod_r[k][80:40]);
        low_r[k] <= prod_r[k][39:0];
        quo_r[k] <= '0;
      end else if (cmd.div_step) begin
        rem_r[k] <= take[k] ? ric_pkg::DEN_W'(trial[k] - {1'b0, den})
                            : ric_pkg::DEN_W'(trial[k]);
        low_r[k] <= {low_r[k][38:0], 1'b0};
        quo_r[k] <= {quo_r[k][38:0], take[k]};
      end
    end
  end

  // signed pixel difference, held at plus or minus 4095 pixels
  logic [40:0]                      qq [2];
  logic signed [42:0]               pix [2];
  logic signed [ric_pkg::DIFF_W-1:0] dclip [2];
  logic signed [ric_pkg::DIFF_W-1:0] diff_r [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      qq[k]  = sat_r[k] ? (41'd1 << 40) : {1'b0, quo_r[k]};
      pix[k] = (neg[k] ? -$signed({2'b0, qq[k]}) : $signed({2'b0, qq[k]}))
               + $signed({27'b0, center_r[16*k +: 16]})
               - $signed({27'b0, key_r[k]});
      if (pix[k] > 43'(ric_pkg::DIFF_LIMIT)) begin
        dclip[k] = ric_pkg::DIFF_LIMIT;
      end else if (pix[k] < -43'(ric_pkg::DIFF_LIMIT)) begin
        dclip[k] = -ric_pkg::DIFF_LIMIT;
      end else begin
        dclip[k] = ric_pkg::DIFF_W'(pix[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff_r[0] <= dclip[0];
      diff_r[1] <= dclip[1];
    end
  end

  // squares, then sum and compare
  logic signed [35:0] sq [2];
  logic [35:0]        sq_r [2];
  logic [31:0]        lim2_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sq[k] = diff_r[k] * diff_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sq_r[0] <= sq[0];
      sq_r[1] <= sq[1];
      lim2_r  <= limit_r * limit_r;
    end
  end

  // verdict
  logic [1:0] verdict_r;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      verdict_r <= !pv_r ? ric_pkg::VERDICT_INVALID : ric_pkg::VERDICT_DEPTH;
    end else if (cmd.cmp) begin
      verdict_r <= ({1'b0, sq_r[0]} + {1'b0, sq_r[1]} <= 37'(lim2_r))
                   ? ric_pkg::VERDICT_INLIER : ric_pkg::VERDICT_ERROR;
    end
  end

  assign sts.point_ok = pv_r && zc_pos;

  // inlier counter and output register
  logic [ric_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic                           inl;
  logic                           ovalid_r;
  logic                           oinl_r, olast_r;
  logic [1:0]                     overd_r;
  logic [15:0]                    otot_r;

  always_comb begin
    inl       = verdict_r == ric_pkg::VERDICT_INLIER;
    count_nxt = count_r;
    if (inl && !(&count_r)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        count_r  <= last_r ? '0 : count_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oinl_r  <= inl;
      overd_r <= verdict_r;
      otot_r  <= ric_pkg::TOTAL_W'(count_nxt);
      olast_r <= last_r;
    end
  end

  assign sts.out_busy        = ovalid_r && !out_ch.ready;
  assign out_ch.valid        = ovalid_r;
  assign out_ch.is_inlier    = oinl_r;
  assign out_ch.verdict      = overd_r;
  assign out_ch.inlier_total = otot_r;
  assign out_ch.last_result  = olast_r;

endmodule
`default_nettype wire

@@ rtl/ric_ctrl.sv @@
// Controller state machine sequencing the datapath for one word at a time.
// Uses ric_pkg command and status types.
`default_nettype none
module ric_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ric_pkg::ric_sts_t sts,
  output logic [1:0]             mac_sel,
  output ric_pkg::ric_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MAC   = 4'd1;
  localparam logic [3:0] ST_CHECK = 4'd2;
  localparam logic [3:0] ST_MULLO = 4'd3;
  localparam logic [3:0] ST_MULHI = 4'd4;
  localparam logic [3:0] ST_DINIT = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_DIFF  = 4'd7;
  localparam logic [3:0] ST_SQR   = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [3:0]                      state_r, state_nxt;
  logic [ric_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign in_ready = state_r == ST_IDLE;
  assign mac_sel  = cnt_r[1:0];

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ric_pkg::DIV_CNT_W'(ric_pkg::MAC_STEPS - 1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.point_ok ? ST_MULLO : ST_EMIT;
      end
      ST_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MULHI;
      end
      ST_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ric_pkg::DIV_CNT_W'(ric_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register frees
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy) else $error("result written over a held result");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r < ric_pkg::DIV_CNT_W'(ric_pkg::DIV_STEPS))
    else $error("divider ran past its last step");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one datapath command at once");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_MAC) else $error("accepted word did not start the transform");

endmodule
`default_nettype wire

@@ rtl/reprojection_inlier_check.sv @@
// Top level of the reprojection inlier check: controller plus datapath.
// Uses ric_pkg, ric_in_if, ric_out_if, ric_ctrl and ric_datapath.
//
//   channel   direction  handshake       payload
//   in_ch     in         valid/ready     point_valid, point_x/y/z, key_u/v, last_point
//   out_ch    out        valid/ready     is_inlier, verdict, inlier_total, last_result
//   cfg       in         cfg_we          cfg_index, cfg_data
//
// A word with a positive depth goes from acceptance to result through the camera
// transform MACs, the depth check, the projection multiply in low and high parts, the
// divider load, the one-bit-per-cycle divider, then difference, square, compare and
// output. Invalid or behind-camera words go from the depth check straight to output.
// One word is in flight at a time; the next is accepted while the previous result
// waits in the output register. Reset is synchronous, active low, and restores the
// identity pose, zero intrinsics and a zero inlier count.
`default_nettype none
module reprojection_inlier_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  ric_in_if.sink           in_ch,
  ric_out_if.source        out_ch
);

  ric_pkg::ric_cmd_t cmd;
  ric_pkg::ric_sts_t sts;
  logic [1:0]        mac_sel;

  ric_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .mac_sel  (mac_sel),
    .cmd      (cmd)
  );

  ric_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_point_valid (in_ch.point_valid),
    .in_point_x     (in_ch.point_x),
    .in_point_y     (in_ch.point_y),
    .in_point_z     (in_ch.point_z),
    .in_key_u       (in_ch.key_u),
    .in_key_v       (in_ch.key_v),
    .in_last_point  (in_ch.last_point),
    .mac_sel        (mac_sel),
    .cmd            (cmd),
    .sts            (sts),
    .out_ch         (out_ch)
  );

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for reprojection_inlier_check: a scoreboard class predicts
// each verdict and the running inlier count. Uses ric_pkg, ric_in_if and ric_out_if.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic               pv;
    logic signed [31:0] x, y, z;
    logic [15:0]        ku, kv;
    logic               last;
  } point_t;

  typedef struct {
    logic        inl;
    logic [1:0]  verdict;
    logic [15:0] total;
    logic        last;
  } verdict_t;

  // Predicts verdicts from a mirror of the pose, intrinsics and inlier count.
  class inlier_scoreboard;
    logic [47:0]                    rot[3];
    logic [62:0]                    trans;
    logic [63:0]                    focal;
    logic [31:0]                    center;
    logic [15:0]                    limit;
    logic [ric_pkg::COUNT_BITS-1:0] count;
    verdict_t                       pending[$];
    int errors, checked, n_inlier, n_invalid, n_depth, n_far;

    function new();
      rot[0] = 48'd16384;
      rot[1] = 48'd16384 << 16;
      rot[2] = 48'd16384 << 32;
      trans = '0;
      focal = '0;
      center = '0;
      limit = '0;
      count = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        ric_pkg::REG_ROT_ROW0:    rot[0] = data[47:0];
        ric_pkg::REG_ROT_ROW1:    rot[1] = data[47:0];
        ric_pkg::REG_ROT_ROW2:    rot[2] = data[47:0];
        ric_pkg::REG_TRANSLATION: trans = data[62:0];
        ric_pkg::REG_FOCAL:       focal = data;
        ric_pkg::REG_CENTER:      center = data[31:0];
        ric_pkg::REG_ERROR_LIMIT: limit = data[15:0];
        default: ;
      endcase
    endfunction

    // Camera coordinate of one axis, Q.30
    function longint cam(int axis, point_t p);
      logic [47:0] r;
      logic [20:0] t;
      longint acc;
      r = rot[axis];
      t = trans[axis*21 +: 21];
      acc = longint'($signed(r[15:0])) * longint'(p.x)
          + longint'($signed(r[31:16])) * longint'(p.y)
          + longint'($signed(r[47:32])) * longint'(p.z);
      return acc + longint'($signed(t)) * 64'sd1048576;
    endfunction

    // Projected pixel in Q12.4: truncated quotient held at 2^40, sign, then center
    function longint pixel_of(longint num, longint den, logic [31:0] f, logic [15:0] c);
      logic [127:0] prod, dd, q;
      longint mag, qv;
      mag = (num < 0) ? -num : num;
      prod = 128'(mag) * 128'(f);
      dd = 128'(den) * 128'd4096;
      q = prod / dd;
      if (q >= (128'd1 << 40)) q = 128'd1 << 40;
      qv = longint'(q[40:0]);
      return ((num < 0) ? -qv : qv) + longint'(c);
    endfunction

    function longint clamp_diff(longint d);
      if (d > 65520) return 65520;
      if (d < -65520) return -65520;
      return d;
    endfunction

    function void note_point(point_t p);
      verdict_t v;
      longint xc, yc, zc, du, dv;
      v.inl = 1'b0;
      v.last = p.last;
      if (!p.pv) begin
        v.verdict = ric_pkg::VERDICT_INVALID;
        n_invalid++;
      end else begin
        xc = cam(0, p);
        yc = cam(1, p);
        zc = cam(2, p);
        if (zc <= 0) begin
          v.verdict = ric_pkg::VERDICT_DEPTH;
          n_depth++;
        end else begin
          du = clamp_diff(pixel_of(xc, zc, focal[31:0], center[15:0]) - longint'(p.ku));
          dv = clamp_diff(pixel_of(yc, zc, focal[63:32], center[31:16]) - longint'(p.kv));
          if (du * du + dv * dv <= longint'(limit) * longint'(limit)) begin
            v.verdict = ric_pkg::VERDICT_INLIER;
            v.inl = 1'b1;
            if (count != '1) count++;
            n_inlier++;
          end else begin
            v.verdict = ric_pkg::VERDICT_ERROR;
            n_far++;
          end
        end
      end
      v.total = count[15:0];
      if (p.last) count = '0;
      pending.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t w;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with no point outstanding");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.inl !== w.inl) begin
        $error("is_inlier: expected %0d, got %0d", w.inl, got.inl);
        errors++;
      end
      if (got.verdict !== w.verdict) begin
        $error("verdict: expected %0d, got %0d", w.verdict, got.verdict);
        errors++;
      end
      if (got.total !== w.total) begin
        $error("inlier_total: expected %0d, got %0d", w.total, got.total);
        errors++;
      end
      if (got.last !== w.last) begin
        $error("last_result: expected %0d, got %0d", w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          accepted;
  int          idle_cycles = 0;

  ric_in_if  in_ch();
  ric_out_if out_ch();
  inlier_scoreboard sb = new();

  reprojection_inlier_check uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.point_valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.key_u = '0;
    in_ch.key_v = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Sample both handshakes mid-cycle; the word moves at the next rising edge
  always @(negedge clk) begin
    verdict_t r;
    accepted = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_point('{in_ch.point_valid, in_ch.point_x, in_ch.point_y, in_ch.point_z,
                      in_ch.key_u, in_ch.key_v, in_ch.last_point});
      accepted = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r = '{out_ch.is_inlier, out_ch.verdict, out_ch.inlier_total, out_ch.last_result};
      sb.check_result(r);
      accepted = 1'b1;
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    idle_cycles <= accepted ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver: random stall bursts, one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    bit ok;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.point_valid <= p.pv;
    in_ch.point_x <= p.x;
    in_ch.point_y <= p.y;
    in_ch.point_z <= p.z;
    in_ch.key_u <= p.ku;
    in_ch.key_v <= p.kv;
    in_ch.last_point <= p.last;
    do begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Drop valid and wait until every outstanding result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] near_key(longint pix, int spread);
    longint k;
    k = pix + $signed($urandom_range(0, 2 * spread)) - spread;
    if (k < 0) k = 0;
    if (k > 65535) k = 65535;
    return k[15:0];
  endfunction

  // Point in front of the camera with keys offset from its true projection
  function automatic point_t aimed(point_t p, int su, int sv, int spread);
    longint zc;
    zc = sb.cam(2, p);
    if (zc > 0) begin
      p.ku = near_key(sb.pixel_of(sb.cam(0, p), zc, sb.focal[31:0], sb.center[15:0]) + su,
                      spread);
      p.kv = near_key(sb.pixel_of(sb.cam(1, p), zc, sb.focal[63:32], sb.center[31:16]) + sv,
                      spread);
    end
    return p;
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int z;
    p.pv = ($urandom_range(0, 15) != 0);
    p.last = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 3) == 0) begin
      p.x = $urandom;
      p.y = $urandom;
      p.z = $urandom;
      p.ku = $urandom;
      p.kv = $urandom;
    end else begin
      z = $urandom_range(1 << 14, 100 << 16);
      p.z = z;
      p.x = $signed($urandom_range(0, z)) - z / 2;
      p.y = $signed($urandom_range(0, z)) - z / 2;
      p = aimed(p, 0, 0, 2 * sb.limit + 4);
    end
    return p;
  endfunction

  task automatic random_points(int n);
    repeat (n) send_point(rand_point());
  endtask

  task automatic typical_pose();
    write_cfg(ric_pkg::REG_ROT_ROW0, 64'd16384);
    write_cfg(ric_pkg::REG_ROT_ROW1, 64'd16384 << 16);
    write_cfg(ric_pkg::REG_ROT_ROW2, 64'd16384 << 32);
    write_cfg(ric_pkg::REG_TRANSLATION, {1'b0, 21'd2048, 21'(-3072), 21'd5120});
    write_cfg(ric_pkg::REG_FOCAL, {32'd500 << 16, 32'd500 << 16});
    write_cfg(ric_pkg::REG_CENTER, {16'd240 << 4, 16'd320 << 4});
    write_cfg(ric_pkg::REG_ERROR_LIMIT, 64'd32);
  endtask

  initial begin
    point_t p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: zero intrinsics project everything to pixel 0
    send_point('{1'b1, 32'sd0, 32'sd0, 32'sd65536, 16'd0, 16'd0, 1'b0});
    send_point('{1'b1, 32'sd0, 32'sd0, 32'sd65536, 16'd1, 16'd0, 1'b0});
    send_point('{1'b0, 32'sd0, 32'sd0, 32'sd65536, 16'd0, 16'd0, 1'b0});
    send_point('{1'b1, 32'sd5, 32'sd5, 32'sd0, 16'd0, 16'd0, 1'b0});
    send_point('{1'b1, 32'sd5, 32'sd5, -32'sd1, 16'd0, 16'd0, 1'b1});
    drain();

    // Typical camera: threshold edges, extreme coordinates and saturation
    typical_pose();
    p = '{1'b1, 32'sd65536, -32'sd65536, 32'sd10 << 16, 16'd0, 16'd0, 1'b0};
    send_point(aimed(p, 0, 0, 0));
    send_point(aimed(p, -32, 0, 0));
    send_point(aimed(p, 0, 32, 0));
    send_point(aimed(p, -33, 0, 0));
    send_point(aimed(p, 0, -33, 0));
    send_point('{1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 16'hffff, 1'b0});
    send_point('{1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h0, 16'h0, 1'b0});
    send_point('{1'b1, 32'h7fffffff, 32'h80000000, 32'h80000000, 16'h0, 16'hffff, 1'b0});
    send_point('{1'b1, 32'h7fffffff, -32'sd1, 32'sd1, 16'h0, 16'h0, 1'b0});
    send_point('{1'b1, 32'sd0, 32'sd0, -32'sd2048, 16'd0, 16'd0, 1'b0});
    send_point('{1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 16'hffff, 1'b0});
    send_point(aimed(p, 0, 0, 0));
    send_point(aimed('{1'b1, 32'sd0, 32'sd0, 32'sd1 << 16, 16'd0, 16'd0, 1'b1}, 0, 0, 0));
    random_points(350);
    drain();

    // Random pose and intrinsics; the receiver stalls long enough to fill the block
    write_cfg(ric_pkg::REG_ROT_ROW0, {$urandom, $urandom});
    write_cfg(ric_pkg::REG_ROT_ROW1, {$urandom, $urandom});
    write_cfg(ric_pkg::REG_ROT_ROW2, {16'd16384, $urandom});
    write_cfg(ric_pkg::REG_TRANSLATION, {$urandom, $urandom});
    write_cfg(ric_pkg::REG_FOCAL, {32'($urandom_range(1 << 16, 2000 << 16)),
                                   32'($urandom_range(1 << 16, 2000 << 16))});
    write_cfg(ric_pkg::REG_CENTER, {$urandom});
    write_cfg(ric_pkg::REG_ERROR_LIMIT, 64'($urandom_range(0, 255)));
    hold_req = 1'b1;
    random_points(200);
    drain();
    random_points(200);
    drain();

    // All-ones registers, and a write to the unused index
    write_cfg(ric_pkg::REG_ROT_ROW0, '1);
    write_cfg(ric_pkg::REG_ROT_ROW1, '1);
    write_cfg(ric_pkg::REG_ROT_ROW2, '1);
    write_cfg(ric_pkg::REG_TRANSLATION, '1);
    write_cfg(ric_pkg::REG_FOCAL, '1);
    write_cfg(ric_pkg::REG_CENTER, '1);
    write_cfg(ric_pkg::REG_ERROR_LIMIT, '1);
    write_cfg(REG_UNUSED, 64'd0);
    send_point('{1'b1, -32'sd65536, -32'sd65536, -32'sd65536, 16'd0, 16'd0, 1'b0});
    send_point('{1'b1, 32'h80000000, 32'h80000000, 32'h80000000, 16'hffff, 16'h0, 1'b0});
    random_points(250);
    drain();

    // All-zero registers: no depth anywhere
    for (int i = 0; i <= int'(ric_pkg::REG_ERROR_LIMIT); i++) write_cfg(3'(i), 64'd0);
    random_points(150);
    drain();

    // Typical camera again, then a final stretch without idling
    typical_pose();
    write_cfg(ric_pkg::REG_ERROR_LIMIT, 64'($urandom_range(1, 65535)));
    random_points(300);
    drain();
    write_cfg(ric_pkg::REG_ERROR_LIMIT, 64'd48);
    quiet = 1'b1;
    random_points(500);
    drain();

    $display("Checked %0d result words: %0d inliers, %0d invalid, %0d behind camera, %0d far",
             sb.checked, sb.n_inlier, sb.n_invalid, sb.n_depth, sb.n_far);
    $display("Poses covered: reset, typical, random, all ones, all zeros; one long stall");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
